// ===== sv/jsu_pkg.sv =====
// Shared types, character codes and helpers for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX
    } phase_t;

    typedef enum logic [2:0] {
        CMD_DATA,
        CMD_DATA_UNTERM,
        CMD_CLOSE,
        CMD_ERR,
        CMD_UNI
    } cmd_kind_t;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_START  = 3'd1;
    localparam logic [2:0] E_ENDESC = 3'd2;
    localparam logic [2:0] E_BADESC = 3'd3;
    localparam logic [2:0] E_UNI    = 3'd4;
    localparam logic [2:0] E_UNTERM = 3'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    // hex digits held before the fourth one arrives
    localparam logic [1:0] HEX_HELD  = 2'd3;

    // result slots of a unicode request
    localparam logic [2:0] UNI_SLOT_BS = 3'd0;
    localparam logic [2:0] UNI_SLOT_U  = 3'd1;
    localparam logic [2:0] UNI_SLOT_D0 = 3'd2;
    localparam logic [2:0] UNI_SLOT_D1 = 3'd3;
    localparam logic [2:0] UNI_SLOT_D2 = 3'd4;
    localparam logic [2:0] UNI_SLOT_LAST = 3'd5;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic [2:0] err;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= CH_0 && c <= CH_9) || (c >= CH_LC_A && c <= CH_LC_F) ||
                 (c >= CH_UC_A && c <= CH_UC_F);
    endfunction

    // {hit, mapped byte} for a simple escape letter
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        case (c)
            CH_QUOTE:  esc_map = {1'b1, CH_QUOTE};
            CH_BSLASH: esc_map = {1'b1, CH_BSLASH};
            CH_SLASH:  esc_map = {1'b1, CH_SLASH};
            CH_LC_B:   esc_map = {1'b1, CH_BS};
            CH_LC_F:   esc_map = {1'b1, CH_FF};
            CH_LC_N:   esc_map = {1'b1, CH_LF};
            CH_LC_R:   esc_map = {1'b1, CH_CR};
            CH_LC_T:   esc_map = {1'b1, CH_TAB};
            default:   esc_map = 9'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== sv/jsu_front.sv =====
// Front end: scans input bytes, tracks string phase, issues result requests.
`default_nettype none
module jsu_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          is_final,
    output jsu_pkg::cmd_t      cmd,
    output logic               push
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      hex_count_reg, hex_count_next;
    logic [7:0]      hex_digits_reg [3];
    logic            hex_wr;
    logic [8:0]      map;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jsu_pkg::PH_IDLE;
            hex_count_reg <= 2'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hex_count_reg <= hex_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hex_wr)
        begin
            hex_digits_reg[hex_count_reg] <= in_byte;
        end
    end

    assign map = jsu_pkg::esc_map(in_byte);

    always_comb
    begin
        phase_next     = phase_reg;
        hex_count_next = hex_count_reg;
        hex_wr         = 1'b0;
        push           = 1'b0;
        cmd.kind       = jsu_pkg::CMD_ERR;
        cmd.ch         = in_byte;
        cmd.err        = jsu_pkg::E_NONE;
        cmd.d0         = hex_digits_reg[0];
        cmd.d1         = hex_digits_reg[1];
        cmd.d2         = hex_digits_reg[2];
        if (accept)
        begin
            case (phase_reg)
                jsu_pkg::PH_IDLE:
                begin
                    if (in_byte != jsu_pkg::CH_QUOTE)
                    begin
                        push    = 1'b1;
                        cmd.err = jsu_pkg::E_START;
                    end
                    else if (is_final)
                    begin
                        push    = 1'b1;
                        cmd.err = jsu_pkg::E_UNTERM;
                    end
                    else
                    begin
                        phase_next = jsu_pkg::PH_BODY;
                    end
                end
                jsu_pkg::PH_BODY:
                begin
                    if (in_byte == jsu_pkg::CH_QUOTE)
                    begin
                        push       = 1'b1;
                        cmd.kind   = jsu_pkg::CMD_CLOSE;
                        phase_next = jsu_pkg::PH_IDLE;
                    end
                    else if (in_byte == jsu_pkg::CH_BSLASH)
                    begin
                        if (is_final)
                        begin
                            push       = 1'b1;
                            cmd.err    = jsu_pkg::E_ENDESC;
                            phase_next = jsu_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = jsu_pkg::PH_ESC;
                        end
                    end
                    else
                    begin
                        push = 1'b1;
                        if (is_final)
                        begin
                            cmd.kind   = jsu_pkg::CMD_DATA_UNTERM;
                            phase_next = jsu_pkg::PH_IDLE;
                        end
                        else
                        begin
                            cmd.kind = jsu_pkg::CMD_DATA;
                        end
                    end
                end
                jsu_pkg::PH_ESC:
                begin
                    if (map[8])
                    begin
                        push   = 1'b1;
                        cmd.ch = map[7:0];
                        if (is_final)
                        begin
                            cmd.kind   = jsu_pkg::CMD_DATA_UNTERM;
                            phase_next = jsu_pkg::PH_IDLE;
                        end
                        else
                        begin
                            cmd.kind   = jsu_pkg::CMD_DATA;
                            phase_next = jsu_pkg::PH_BODY;
                        end
                    end
                    else if (in_byte == jsu_pkg::CH_LC_U)
                    begin
                        hex_count_next = 2'd0;
                        if (is_final)
                        begin
                            push       = 1'b1;
                            cmd.err    = jsu_pkg::E_UNI;
                            phase_next = jsu_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = jsu_pkg::PH_HEX;
                        end
                    end
                    else
                    begin
                        push       = 1'b1;
                        cmd.err    = jsu_pkg::E_BADESC;
                        phase_next = jsu_pkg::PH_IDLE;
                    end
                end
                jsu_pkg::PH_HEX:
                begin
                    if (is_final || !jsu_pkg::is_hex(in_byte))
                    begin
                        push           = 1'b1;
                        cmd.err        = jsu_pkg::E_UNI;
                        phase_next     = jsu_pkg::PH_IDLE;
                        hex_count_next = 2'd0;
                    end
                    else if (hex_count_reg != jsu_pkg::HEX_HELD)
                    begin
                        hex_wr         = 1'b1;
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else
                    begin
                        push           = 1'b1;
                        cmd.kind       = jsu_pkg::CMD_UNI;
                        phase_next     = jsu_pkg::PH_BODY;
                        hex_count_next = 2'd0;
                    end
                end
                default:
                begin
                    phase_next     = jsu_pkg::PH_IDLE;
                    hex_count_next = 2'd0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/jsu_queue.sv =====
// Small request queue between the front end and the result sequencer.
`default_nettype none
module jsu_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jsu_pkg::cmd_t wr_cmd,
    input  wire logic          pop,
    output jsu_pkg::cmd_t      rd_cmd,
    output logic               not_empty,
    output logic               full
);

    jsu_pkg::cmd_t                 mem [jsu_pkg::QDEPTH];
    logic [jsu_pkg::QAW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [jsu_pkg::QAW:0]         count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign rd_cmd    = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (jsu_pkg::QAW+1)'(jsu_pkg::QDEPTH));

endmodule
`default_nettype wire

// ===== sv/jsu_back.sv =====
// Back end: expands each request into its result bytes into an output register.
`default_nettype none
module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jsu_pkg::cmd_t head,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         decoded_byte,
    output logic [1:0]         status,
    output logic [2:0]         error_code,
    output logic               run_last
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] status_reg;
    logic [2:0] err_reg;
    logic       last_reg;
    logic       step;
    logic [7:0] r_byte;
    logic [1:0] r_status;
    logic [2:0] r_err;
    logic       r_last;

    always_comb
    begin
        r_byte   = 8'd0;
        r_status = jsu_pkg::ST_DATA;
        r_err    = jsu_pkg::E_NONE;
        r_last   = 1'b1;
        case (head.kind)
            jsu_pkg::CMD_DATA:
            begin
                r_byte = head.ch;
            end
            jsu_pkg::CMD_DATA_UNTERM:
            begin
                if (idx_reg == 3'd0)
                begin
                    r_byte = head.ch;
                    r_last = 1'b0;
                end
                else
                begin
                    r_status = jsu_pkg::ST_ERR;
                    r_err    = jsu_pkg::E_UNTERM;
                end
            end
            jsu_pkg::CMD_CLOSE:
            begin
                r_status = jsu_pkg::ST_CLOSE;
            end
            jsu_pkg::CMD_ERR:
            begin
                r_status = jsu_pkg::ST_ERR;
                r_err    = head.err;
            end
            jsu_pkg::CMD_UNI:
            begin
                r_last = (idx_reg == jsu_pkg::UNI_SLOT_LAST);
                case (idx_reg)
                    jsu_pkg::UNI_SLOT_BS: r_byte = jsu_pkg::CH_BSLASH;
                    jsu_pkg::UNI_SLOT_U:  r_byte = jsu_pkg::CH_LC_U;
                    jsu_pkg::UNI_SLOT_D0: r_byte = head.d0;
                    jsu_pkg::UNI_SLOT_D1: r_byte = head.d1;
                    jsu_pkg::UNI_SLOT_D2: r_byte = head.d2;
                    default:              r_byte = head.ch;
                endcase
            end
            default:
            begin
                r_status = jsu_pkg::ST_ERR;
                r_err    = head.err;
            end
        endcase
    end

    assign step = head_valid && (!out_valid_reg || out_ready);
    assign pop  = step && r_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = 3'd0;
        end
        else if (step)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            byte_reg   <= r_byte;
            status_reg <= r_status;
            err_reg    <= r_err;
            last_reg   <= r_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign decoded_byte = byte_reg;
    assign status       = status_reg;
    assign error_code   = err_reg;
    assign run_last     = last_reg;

endmodule
`default_nettype wire

// ===== sv/json_string_unescaper.sv =====
// An accepted byte's request is written into the queue, and its first result is then
// registered into the output register once that is empty or being taken. Input is taken
// whenever the queue has room, one byte per cycle, and one result per cycle leaves while
// results are taken; a unicode escape gives six results from one request, so bytes right
// behind it can stall on the full four-entry queue. Output stalls reach input only through
// the queue. Reset (rst_n low, asynchronous) empties queue and output.
`default_nettype none
module json_string_unescaper (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        is_final,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       decoded_byte,
    output logic [1:0]       status,
    output logic [2:0]       error_code,
    output logic             run_last
);

    jsu_pkg::cmd_t wr_cmd;
    jsu_pkg::cmd_t head;
    logic          push;
    logic          pop;
    logic          not_empty;
    logic          full;
    logic          accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .is_final (is_final),
        .cmd      (wr_cmd),
        .push     (push)
    );

    jsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (wr_cmd),
        .pop       (pop),
        .rd_cmd    (head),
        .not_empty (not_empty),
        .full      (full)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (not_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .decoded_byte (decoded_byte),
        .status       (status),
        .error_code   (error_code),
        .run_last     (run_last)
    );

endmodule
`default_nettype wire
